>>> rtl/gpbt_pkg.sv
// ----------------------------------------------------------------------------
// gpbt_pkg
// Shared types and constants of the glyph proportion bound tuner.
// ----------------------------------------------------------------------------
package gpbt_pkg;

	// default parameter values
	localparam int DIM_BITS_DEF   = 10;
	localparam int COUNT_BITS_DEF = 8;

	// fixed field widths
	localparam int KIND_BITS  = 2;
	localparam int BOUND_BITS = 8;
	localparam int PASS_BITS  = 4;
	localparam int DELTA_BITS = 8;
	localparam int VOTE_BITS  = 3;
	localparam int OUT_BITS   = 2 * DELTA_BITS + VOTE_BITS + 2;
	localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

	// aspect ratio arithmetic
	localparam int RATIO_FRAC_BITS = 6;                    // ratio = 64*min/max
	localparam int QUO_BITS        = RATIO_FRAC_BITS + 1;  // quotient 0..64
	localparam int RATIO_BITS      = RATIO_FRAC_BITS + 2;  // ratio 0..128
	localparam int RATIO_FULL      = 128;
	localparam int IDX_BITS        = RATIO_BITS + 2;       // 7*ratio, up to 896
	localparam int ASPECT_MUL      = 7;
	localparam int BOUND_MUL       = 6;
	localparam int CMP_BITS        = 13;                   // signed bound range
	localparam int FAX_HEIGHT_ADD  = 2;

	// delta limits
	localparam int DELTA_LIMIT    = 14;
	localparam int ONE_LINE_LIMIT = 4;

	// configuration port
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic REG_ENABLE  = 1'b0;
	localparam logic REG_DHF     = 1'b1;

	// cell kinds
	typedef enum logic [KIND_BITS-1:0] {
		KIND_GOOD  = 2'd0,
		KIND_BAD   = 2'd1,
		KIND_OTHER = 2'd2
	} kind_t;

	// configuration register contents
	typedef struct packed {
		logic enable;
		logic double_height_fax;
	} cfg_t;

endpackage

>>> rtl/gpbt_cfg_regs.sv
// ----------------------------------------------------------------------------
// gpbt_cfg_regs
// APB register file: enable and double height fax mode.
// ----------------------------------------------------------------------------
module gpbt_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gpbt_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [gpbt_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [gpbt_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready,
	output gpbt_pkg::cfg_t                       cfg
);

	logic reg_idx;
	logic wr_en;
	logic rd_bit;
	gpbt_pkg::cfg_t cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel & penable & pwrite & pready;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable            <= 1'b1;
			cfg_q.double_height_fax <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				gpbt_pkg::REG_ENABLE: cfg_q.enable            <= pwdata[0];
				gpbt_pkg::REG_DHF:    cfg_q.double_height_fax <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux, word aligned addresses only
	always_comb begin
		unique case (reg_idx)
			gpbt_pkg::REG_ENABLE: rd_bit = cfg_q.enable;
			gpbt_pkg::REG_DHF:    rd_bit = cfg_q.double_height_fax;
			default:              rd_bit = 1'b0;
		endcase
		prdata = (paddr[1:0] == 2'b00) ?
			{{(gpbt_pkg::APB_DATA_BITS-1){1'b0}}, rd_bit} : '0;
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/gpbt_divider.sv
// ----------------------------------------------------------------------------
// gpbt_divider
// Restoring divider, one quotient bit per cycle: quo = (num << (QBITS-1)) / den
// with num <= den, so the quotient fits in QBITS bits.
// ----------------------------------------------------------------------------
module gpbt_divider #(
	parameter int WIDTH = gpbt_pkg::DIM_BITS_DEF + 1,
	parameter int QBITS = gpbt_pkg::QUO_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] num,
	input  logic [WIDTH-1:0] den,
	output logic             done,
	output logic [QBITS-1:0] quo
);

	localparam int CNT_BITS = (QBITS > 1) ? $clog2(QBITS) : 1;

	logic [WIDTH:0]    rem_q;
	logic [WIDTH-1:0]  den_q;
	logic [QBITS-1:0]  quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic              ge;
	logic [WIDTH:0]    diff;
	logic [WIDTH:0]    r_next;

	// one compare and subtract per step
	assign ge     = rem_q >= {1'b0, den_q};
	assign diff   = rem_q - {1'b0, den_q};
	assign r_next = ge ? diff : rem_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(QBITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {r_next[WIDTH-1:0], 1'b0};
			quo_q <= {quo_q[QBITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	// checks
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still busy");

endmodule

>>> rtl/glyph_proportion_bound_tuner.sv
// ----------------------------------------------------------------------------
// glyph_proportion_bound_tuner
// Per-line tuning of the letter aspect bound widenings.
// ----------------------------------------------------------------------------
// Cells of a text line enter on the s_ stream, one cell per word, the last
// cell of the line marked by s_tlast. Each well recognized letter gets an
// aspect index from one serial division (one quotient bit per cycle) and is
// counted against its bounds; refused letters bump the extra counters.
// On the last cell the two widening deltas are updated and one result word
// (deltas, vote count, flags) leaves on the m_ stream.
// s_tready is high only while the sequencer is idle. A letter cell passes
// LOAD, the 7 step divide (DIV, skipped for a zero larger side) and EVAL
// before the next s_tready; any other cell passes LOAD only. A last cell adds
// the end-of-line update (FIN1, FIN2); m_tvalid rises once FIN2 loads the result.
// The result sits in an output register; a stalled receiver holds it there
// while the block goes on with the next line, and only the next result
// waits for it. With enable low, accepted cells are dropped.
// Reset clears the deltas and counters and starts a new line; the APB
// registers return to enable = 1, double_height_fax = 0.
// ----------------------------------------------------------------------------
module glyph_proportion_bound_tuner #(
	parameter int DIM_BITS   = gpbt_pkg::DIM_BITS_DEF,
	parameter int COUNT_BITS = gpbt_pkg::COUNT_BITS_DEF,
	localparam int IN_BITS   = 2 * DIM_BITS + 2 * gpbt_pkg::BOUND_BITS + 2 +
	                           gpbt_pkg::PASS_BITS,
	localparam int IN_DATA_BITS = ((IN_BITS + 7) / 8) * 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// cell stream
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// height, width, bound_min, bound_max, refused_wide, refused_narrow,
	// pass_index (lowest bits first), zero padded
	input  logic [IN_DATA_BITS-1:0]                  s_tdata,
	// kind
	input  logic [gpbt_pkg::KIND_BITS-1:0]           s_tuser,
	input  logic                                     s_tlast,
	// result stream
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// left_delta, right_delta, rerecog_votes, trouble, final_rerecog
	// (lowest bits first), zero padded
	output logic [gpbt_pkg::OUT_DATA_BITS-1:0]       m_tdata,
	// configuration
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [gpbt_pkg::APB_ADDR_BITS-1:0]       paddr,
	input  logic [gpbt_pkg::APB_DATA_BITS-1:0]       pwdata,
	output logic [gpbt_pkg::APB_DATA_BITS-1:0]       prdata,
	output logic                                     pready
);

	localparam int H_BITS  = DIM_BITS + 1;
	localparam int VW      = COUNT_BITS + 5;
	localparam int DB      = gpbt_pkg::DELTA_BITS;
	localparam int BB      = gpbt_pkg::BOUND_BITS;
	localparam int CB      = gpbt_pkg::CMP_BITS;
	localparam int OFS_W   = DIM_BITS;
	localparam int OFS_A   = 2 * DIM_BITS;
	localparam int OFS_B   = OFS_A + BB;
	localparam int OFS_RW  = OFS_B + BB;
	localparam int OFS_RN  = OFS_RW + 1;
	localparam int OFS_P   = OFS_RN + 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [DB-1:0]         DLT_MAX = '1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_EVAL = 6'b001000,
		ST_FIN1 = 6'b010000,
		ST_FIN2 = 6'b100000
	} state_t;

	// saturating increments
	function automatic logic [COUNT_BITS-1:0] cnt_up(input logic [COUNT_BITS-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

	function automatic logic [DB-1:0] dlt_up(input logic [DB-1:0] d);
		return (d == DLT_MAX) ? d : d + 1'b1;
	endfunction

	// one side of the end-of-line delta update
	function automatic logic [DB-1:0] side_update(
		input logic [DB-1:0]         d,
		input logic [COUNT_BITS-1:0] plain,
		input logic [COUNT_BITS-1:0] extra,
		input logic [COUNT_BITS-1:0] n,
		input logic                  pass_nz
	);
		logic [DB-1:0] d1;
		logic [DB-1:0] d2;
		logic [VW-1:0] v;
		d1 = (plain > COUNT_BITS'(3)) ? dlt_up(d) : d;
		d2 = d1;
		v  = VW'(plain);
		if (d1 == '0 || pass_nz) begin
			if (extra > COUNT_BITS'(1))
				d2 = dlt_up(d1);
			else
				v = v + (VW'(extra) << 1);
		end
		return ((v << 3) > VW'(n)) ? dlt_up(d2) : d2;
	endfunction

	// one side's vote, 0 or 1
	function automatic logic side_vote(
		input logic [COUNT_BITS-1:0] base,
		input logic [COUNT_BITS-1:0] extra,
		input logic [COUNT_BITS-1:0] n
	);
		logic more;
		logic one;
		logic none;
		more = extra > COUNT_BITS'(1);
		one  = (extra == COUNT_BITS'(1)) && (((VW'(base) + 1'b1) << 3) > VW'(n));
		none = (extra == '0) && ((VW'(base) << 2) > VW'(n));
		return more | one | none;
	endfunction

	gpbt_pkg::cfg_t cfg;
	state_t state_q, state_d;

	// latched cell
	gpbt_pkg::kind_t     kind_q;
	logic [H_BITS-1:0]   hgt_q;
	logic [DIM_BITS-1:0] wid_q;
	logic [BB-1:0]       a_q, b_q;
	logic                rw_q, rn_q, last_q;
	logic [gpbt_pkg::PASS_BITS-1:0] pass_q;

	// line state
	logic [DB-1:0]         left_q, right_q;
	logic [COUNT_BITS-1:0] cell_q, narrow_q, wide_q, mnarrow_q, mwide_q;
	logic [COUNT_BITS-1:0] xnarrow_q, xwide_q;
	logic                  line_start_q;

	// output register
	logic                               m_tvalid_q;
	logic [gpbt_pkg::OUT_DATA_BITS-1:0] m_tdata_q;

	logic in_acc, out_load, pass_nz;
	logic [H_BITS-1:0] h_in, w_ext, div_num, div_den;
	logic w_gt, den_zero, div_start, div_done;
	logic [gpbt_pkg::QUO_BITS-1:0] quo;
	logic [gpbt_pkg::RATIO_BITS-1:0] ratio;
	logic [gpbt_pkg::IDX_BITS-1:0] idx;
	logic signed [CB-1:0] idx_s, a_s, b_s, l_s, r_s, lo, hi, mlo, mhi;
	logic [COUNT_BITS-1:0] cell_b, narrow_b, wide_b, mnarrow_b, mwide_b, xn_b, xw_b;
	logic [VW-1:0] vl, vr;
	logic [DB-1:0] left_upd, right_upd;
	logic one_line;
	logic [gpbt_pkg::VOTE_BITS-1:0] votes;
	logic trouble, final_rerecog;

	gpbt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gpbt_divider #(
		.WIDTH (H_BITS),
		.QBITS (gpbt_pkg::QUO_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	// handshake
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	assign out_load = (state_q == ST_FIN2) & (~m_tvalid_q | m_tready);
	assign pass_nz  = (pass_q != '0);

	// height, widened in fax mode
	assign h_in = H_BITS'(s_tdata[DIM_BITS-1:0]) +
		(cfg.double_height_fax ? H_BITS'(gpbt_pkg::FAX_HEIGHT_ADD) : '0);

	// divider operands: smaller side over larger side
	assign w_ext     = H_BITS'(wid_q);
	assign w_gt      = w_ext > hgt_q;
	assign div_num   = w_gt ? hgt_q : w_ext;
	assign div_den   = w_gt ? w_ext : hgt_q;
	assign den_zero  = (div_den == '0);
	assign div_start = (state_q == ST_LOAD) && (kind_q == gpbt_pkg::KIND_GOOD) && !den_zero;

	// aspect index and bounds
	always_comb begin
		if (den_zero)
			ratio = '0;
		else if (w_gt)
			ratio = gpbt_pkg::RATIO_BITS'(gpbt_pkg::RATIO_FULL) - gpbt_pkg::RATIO_BITS'(quo);
		else
			ratio = gpbt_pkg::RATIO_BITS'(quo);
		idx   = gpbt_pkg::IDX_BITS'(ratio) * gpbt_pkg::IDX_BITS'(gpbt_pkg::ASPECT_MUL);
		idx_s = $signed(CB'(idx));
		a_s   = $signed(CB'(a_q));
		b_s   = $signed(CB'(b_q));
		l_s   = $signed(CB'(left_q));
		r_s   = $signed(CB'(right_q));
		lo    = (a_s - l_s) * $signed(CB'(gpbt_pkg::BOUND_MUL)) + b_s;
		hi    = (b_s + r_s) * $signed(CB'(gpbt_pkg::BOUND_MUL)) + a_s;
		mlo   = a_s * $signed(CB'(gpbt_pkg::BOUND_MUL)) + b_s;
		mhi   = b_s * $signed(CB'(gpbt_pkg::BOUND_MUL)) + a_s;
	end

	// counters as seen by this cell, cleared at line start
	always_comb begin
		cell_b    = line_start_q ? '0 : cell_q;
		narrow_b  = line_start_q ? '0 : narrow_q;
		wide_b    = line_start_q ? '0 : wide_q;
		mnarrow_b = line_start_q ? '0 : mnarrow_q;
		mwide_b   = line_start_q ? '0 : mwide_q;
		xn_b      = line_start_q ? '0 : xnarrow_q;
		xw_b      = line_start_q ? '0 : xwide_q;
	end

	// end-of-line delta update
	always_comb begin
		left_upd  = side_update(left_q, narrow_q, xnarrow_q, cell_q, pass_nz);
		right_upd = side_update(right_q, wide_q, xwide_q, cell_q, pass_nz);
		vl = (VW'(xnarrow_q) << 1) + VW'(mnarrow_q);
		vr = (VW'(xwide_q) << 1) + VW'(mwide_q);
		if (!pass_nz) begin
			if (vl < VW'(4) && (vl << 3) < VW'(cell_q))
				left_upd = '0;
			if (vr < VW'(4) && (vr << 3) < VW'(cell_q))
				right_upd = '0;
		end
	end

	// votes from the line counters, flags from the final deltas
	always_comb begin
		one_line = (cell_q == COUNT_BITS'(1)) &&
			(left_q > DB'(gpbt_pkg::ONE_LINE_LIMIT) ||
			 right_q > DB'(gpbt_pkg::ONE_LINE_LIMIT));
		if (one_line)
			votes = '0;
		else if (pass_nz)
			votes = gpbt_pkg::VOTE_BITS'(side_vote(narrow_q, xnarrow_q, cell_q)) +
				gpbt_pkg::VOTE_BITS'(side_vote(wide_q, xwide_q, cell_q));
		else
			votes = gpbt_pkg::VOTE_BITS'(side_vote(mnarrow_q, xnarrow_q, cell_q)) +
				gpbt_pkg::VOTE_BITS'(side_vote(mwide_q, xwide_q, cell_q));
		trouble = (left_q > DB'(gpbt_pkg::DELTA_LIMIT)) ||
			(right_q > DB'(gpbt_pkg::DELTA_LIMIT));
		final_rerecog = (votes == '0) && (left_q != '0 || right_q != '0);
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc && cfg.enable) state_d = ST_LOAD;
			ST_LOAD: begin
				if (kind_q == gpbt_pkg::KIND_GOOD)
					state_d = den_zero ? ST_EVAL : ST_DIV;
				else
					state_d = last_q ? ST_FIN1 : ST_IDLE;
			end
			ST_DIV:  if (div_done) state_d = ST_EVAL;
			ST_EVAL: state_d = last_q ? ST_FIN1 : ST_IDLE;
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// cell capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= gpbt_pkg::kind_t'(s_tuser);
			hgt_q  <= h_in;
			wid_q  <= s_tdata[OFS_W +: DIM_BITS];
			a_q    <= s_tdata[OFS_A +: BB];
			b_q    <= s_tdata[OFS_B +: BB];
			rw_q   <= s_tdata[OFS_RW];
			rn_q   <= s_tdata[OFS_RN];
			pass_q <= s_tdata[OFS_P +: gpbt_pkg::PASS_BITS];
			last_q <= s_tlast;
		end
	end

	// line state: counters and deltas
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			right_q      <= '0;
			cell_q       <= '0;
			narrow_q     <= '0;
			wide_q       <= '0;
			mnarrow_q    <= '0;
			mwide_q      <= '0;
			xnarrow_q    <= '0;
			xwide_q      <= '0;
			line_start_q <= 1'b1;
		end else begin
			if (state_q == ST_LOAD) begin
				cell_q    <= cnt_up(cell_b);
				narrow_q  <= narrow_b;
				wide_q    <= wide_b;
				mnarrow_q <= mnarrow_b;
				mwide_q   <= mwide_b;
				xnarrow_q <= (kind_q == gpbt_pkg::KIND_BAD && rn_q) ? cnt_up(xn_b) : xn_b;
				xwide_q   <= (kind_q == gpbt_pkg::KIND_BAD && rw_q) ? cnt_up(xw_b) : xw_b;
				// first pass over a line drops runaway deltas
				if (line_start_q && !pass_nz) begin
					if (left_q > DB'(gpbt_pkg::DELTA_LIMIT))
						left_q <= '0;
					if (right_q > DB'(gpbt_pkg::DELTA_LIMIT))
						right_q <= '0;
				end
				line_start_q <= 1'b0;
			end
			if (state_q == ST_EVAL) begin
				if (idx_s < lo)  narrow_q  <= cnt_up(narrow_q);
				if (idx_s > hi)  wide_q    <= cnt_up(wide_q);
				if (idx_s < mlo) mnarrow_q <= cnt_up(mnarrow_q);
				if (idx_s > mhi) mwide_q   <= cnt_up(mwide_q);
			end
			if (state_q == ST_FIN1) begin
				left_q  <= left_upd;
				right_q <= right_upd;
			end
			if (out_load)
				line_start_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_tdata_q <= gpbt_pkg::OUT_DATA_BITS'({final_rerecog, trouble, votes,
				right_q, left_q});
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV) else $error("division result outside divide step");
	a_disabled_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !cfg.enable) |=> state_q == ST_IDLE)
		else $error("cell processed while disabled");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_FIN2))
		else $error("result word without end-of-line update");
	a_eval_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> !line_start_q) else $error("letter counted before line start");
	a_new_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (line_start_q && state_q == ST_IDLE))
		else $error("line not restarted after result");

endmodule
